FILE: hw/rtl/iclr_pkg.sv
// ============================================================================
// Inode cache package
// Shared constants, codes and struct types for the inode cache with use
// counts and share counts.
// ============================================================================
package iclr_pkg;

   // Table geometry.
   localparam int ENTRIES = 64;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = IDX_W + 1;

   // Result status codes.
   localparam logic [2:0] ST_HIT      = 3'd0;
   localparam logic [2:0] ST_FREE     = 3'd1;
   localparam logic [2:0] ST_EVICT    = 3'd2;
   localparam logic [2:0] ST_NONE     = 3'd3;
   localparam logic [2:0] ST_PUT_NOWR = 3'd4;
   localparam logic [2:0] ST_PUT_WB   = 3'd5;
   localparam logic [2:0] ST_NULL_PUT = 3'd6;
   localparam logic [2:0] ST_BAD_PUT  = 3'd7;

   // Request type codes.
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_IPB   = 2'd0;
   localparam logic [1:0] CSR_START = 2'd1;
   localparam logic [1:0] CSR_FAC   = 2'd2;

   // Saturation limits.
   localparam logic [15:0] USE_MAX   = 16'hFFFF;
   localparam logic [7:0]  USERS_MAX = 8'hFF;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  dev;
      logic [31:0] ino;
      logic [5:0]  target_entry;
      logic        has_entry;
      logic        dirty;
   } iclr_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  entry_index;
      logic [32:0] inode_block;
      logic [8:0]  inode_slot;
      logic [7:0]  share_count;
      logic [31:0] request_total;
      logic [31:0] hit_total;
   } iclr_rsp_type;

   // One cached table entry as held in the entry memory.
   typedef struct packed {
      logic [7:0]  dev;
      logic [31:0] ino;
      logic [15:0] use_cnt;
      logic [7:0]  users;
      logic        modf;
   } iclr_rec_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan_step;
      logic get_commit;
      logic put_commit;
      logic set_reject;
      logic div_start;
      logic loc_load;
      logic out_load;
   } iclr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_get;
      logic put_ok;
      logic scan_done;
      logic need_div;
      logic div_done;
      logic out_free;
   } iclr_stat_type;

endpackage

FILE: hw/rtl/iclr_div.sv
// ============================================================================
// Inode cache divider
// Restoring divider that produces one quotient bit per cycle for the
// inode number split into block and slot.
// ============================================================================
module iclr_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [6:0]  divisor,
   output logic        done,
   output logic [31:0] quo,
   output logic [6:0]  rem
);
   import iclr_pkg::*;

   logic [31:0] quo_ff, quo_in;
   logic [6:0]  rem_ff, rem_in;
   logic [6:0]  dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [7:0]  trial;
   logic        fits;

   // One trial subtraction per cycle.
   assign trial = {rem_ff, quo_ff[31]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = 7'd0;
         dvs_in  = divisor;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], fits};
         rem_in = fits ? 7'(trial - {1'b0, dvs_ff}) : trial[6:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

FILE: hw/rtl/iclr_dp.sv
// ============================================================================
// Inode cache datapath
// Entry memory, valid bits, scan and victim tracking, counters, location
// arithmetic, configuration registers and the result register.
// ============================================================================
module iclr_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  iclr_pkg::iclr_req_type req_data,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_wdata,
   input  iclr_pkg::iclr_cmd_type cmd,
   output iclr_pkg::iclr_stat_type st,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output iclr_pkg::iclr_rsp_type rsp_data
);
   import iclr_pkg::*;

   // Configuration registers.
   logic [6:0]  ipb_ff;
   logic [31:0] start_ff;
   logic [3:0]  fac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ipb_ff   <= 7'd8;
         start_ff <= 32'd0;
         fac_ff   <= 4'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IPB:   ipb_ff   <= csr_wdata[6:0];
            CSR_START: start_ff <= csr_wdata;
            CSR_FAC:   fac_ff   <= csr_wdata[3:0];
            default:   ;
         endcase
      end
   end

   // Captured request word.
   iclr_req_type req_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // Entry memory and valid bits.
   iclr_rec_type           mem [ENTRIES];
   iclr_rec_type           rdata_ff;
   logic [IDX_W-1:0]       raddr;
   logic                   we;
   logic [IDX_W-1:0]       waddr;
   iclr_rec_type           wdata;
   logic [ENTRIES-1:0]     valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   // Scan pipeline: issue one read a cycle, evaluate each word from the read register.
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic             rv_ff, rv_in;
   logic [IDX_W-1:0] ridx_ff;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   iclr_rec_type     hit_rec_ff, hit_rec_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             vic_ff, vic_in;
   logic [IDX_W-1:0] vic_idx_ff, vic_idx_in;
   logic [15:0]      vic_use_ff, vic_use_in;
   logic             rvalid;
   logic             put_ok;

   assign rvalid = valid_ff[ridx_ff];
   assign put_ok = req_ff.has_entry && (32'(req_ff.target_entry) < ENTRIES)
                   && valid_ff[req_ff.target_entry[IDX_W-1:0]];

   always_comb begin
      scan_cnt_in = scan_cnt_ff;
      rv_in       = 1'b0;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_rec_in  = hit_rec_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      vic_in      = vic_ff;
      vic_idx_in  = vic_idx_ff;
      vic_use_in  = vic_use_ff;
      if (req_ff.req_type == REQ_GET) begin
         raddr = scan_cnt_ff[IDX_W-1:0];
      end else begin
         raddr = req_ff.target_entry[IDX_W-1:0];
      end
      if (cmd.load) begin
         scan_cnt_in = '0;
         hit_in      = 1'b0;
         free_in     = 1'b0;
         vic_in      = 1'b0;
      end else if (cmd.scan_step) begin
         if (32'(scan_cnt_ff) < ENTRIES) begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
            rv_in       = 1'b1;
         end
         if (rv_ff) begin
            if (rvalid && !hit_ff && rdata_ff.dev == req_ff.dev
                && rdata_ff.ino == req_ff.ino) begin
               hit_in     = 1'b1;
               hit_idx_in = ridx_ff;
               hit_rec_in = rdata_ff;
            end
            if (!rvalid && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = ridx_ff;
            end
            if (rvalid && rdata_ff.users == 8'd0
                && (!vic_ff || rdata_ff.use_cnt < vic_use_ff)) begin
               vic_in     = 1'b1;
               vic_idx_in = ridx_ff;
               vic_use_in = rdata_ff.use_cnt;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= rv_in;
      end
      ridx_ff     <= raddr;
      scan_cnt_ff <= scan_cnt_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_rec_ff  <= hit_rec_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      vic_ff      <= vic_in;
      vic_idx_ff  <= vic_idx_in;
      vic_use_ff  <= vic_use_in;
   end

   // Put evaluation from the target word.
   logic       put_mod;
   logic [7:0] put_users;
   logic       put_wb;

   assign put_mod   = rdata_ff.modf | req_ff.dirty;
   assign put_users = (rdata_ff.users != 8'd0) ? rdata_ff.users - 8'd1 : 8'd0;
   assign put_wb    = (put_users == 8'd0) && put_mod;

   // Commit: table update, result fields and counters.
   logic [31:0] req_cnt_ff, req_cnt_in;
   logic [31:0] hit_cnt_ff, hit_cnt_in;
   logic [2:0]  res_status_ff, res_status_in;
   logic [5:0]  res_idx_ff, res_idx_in;
   logic [7:0]  res_share_ff, res_share_in;
   logic [32:0] res_blk_ff, res_blk_in;
   logic [8:0]  res_slot_ff, res_slot_in;
   iclr_rec_type fill_rec;
   logic        fill;
   logic [IDX_W-1:0] fill_idx;

   assign fill     = free_ff || vic_ff;
   assign fill_idx = free_ff ? free_idx_ff : vic_idx_ff;

   always_comb begin
      fill_rec.dev     = req_ff.dev;
      fill_rec.ino     = req_ff.ino;
      fill_rec.use_cnt = 16'd1;
      fill_rec.users   = 8'd1;
      fill_rec.modf    = 1'b0;
   end

   // Divider and location arithmetic.
   logic [6:0]  ipb_eff;
   logic [3:0]  fac_eff;
   logic [31:0] dividend;
   logic        div_done;
   logic [31:0] div_quo;
   logic [6:0]  div_rem;

   always_comb begin
      if (ipb_ff == 7'd0) begin
         ipb_eff = 7'd1;
      end else if (ipb_ff > 7'd64) begin
         ipb_eff = 7'd64;
      end else begin
         ipb_eff = ipb_ff;
      end
      if (fac_ff == 4'd0) begin
         fac_eff = 4'd1;
      end else if (fac_ff > 4'd8) begin
         fac_eff = 4'd8;
      end else begin
         fac_eff = fac_ff;
      end
   end

   assign dividend = ((req_ff.req_type == REQ_GET) ? req_ff.ino : rdata_ff.ino) - 32'd1;

   iclr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (ipb_eff),
      .done     (div_done),
      .quo      (div_quo),
      .rem      (div_rem)
   );

   always_comb begin
      we            = 1'b0;
      waddr         = fill_idx;
      wdata         = fill_rec;
      valid_in      = valid_ff;
      req_cnt_in    = req_cnt_ff;
      hit_cnt_in    = hit_cnt_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_share_in  = res_share_ff;
      res_blk_in    = res_blk_ff;
      res_slot_in   = res_slot_ff;
      if (cmd.load) begin
         res_idx_in   = 6'd0;
         res_share_in = 8'd0;
         res_blk_in   = 33'd0;
         res_slot_in  = 9'd0;
         if (req_data.req_type == REQ_GET) begin
            req_cnt_in = req_cnt_ff + 32'd1;
         end
      end
      if (cmd.set_reject) begin
         if (!req_ff.has_entry) begin
            res_status_in = ST_NULL_PUT;
         end else begin
            res_status_in = ST_BAD_PUT;
            res_idx_in    = req_ff.target_entry;
         end
      end
      if (cmd.get_commit) begin
         if (hit_ff) begin
            we            = 1'b1;
            waddr         = hit_idx_ff;
            wdata         = hit_rec_ff;
            if (hit_rec_ff.use_cnt != USE_MAX) begin
               wdata.use_cnt = hit_rec_ff.use_cnt + 16'd1;
            end
            if (hit_rec_ff.users != USERS_MAX) begin
               wdata.users = hit_rec_ff.users + 8'd1;
            end
            hit_cnt_in    = hit_cnt_ff + 32'd1;
            res_status_in = ST_HIT;
            res_idx_in    = 6'(hit_idx_ff);
            res_share_in  = wdata.users;
         end else if (fill) begin
            we                  = 1'b1;
            valid_in[fill_idx]  = 1'b1;
            res_status_in       = free_ff ? ST_FREE : ST_EVICT;
            res_idx_in          = 6'(fill_idx);
            res_share_in        = 8'd1;
         end else begin
            res_status_in = ST_NONE;
         end
      end
      if (cmd.put_commit) begin
         we            = 1'b1;
         waddr         = req_ff.target_entry[IDX_W-1:0];
         wdata         = rdata_ff;
         wdata.users   = put_users;
         wdata.modf    = put_wb ? 1'b0 : put_mod;
         res_status_in = put_wb ? ST_PUT_WB : ST_PUT_NOWR;
         res_idx_in    = req_ff.target_entry;
         res_share_in  = put_users;
      end
      if (cmd.loc_load) begin
         res_blk_in  = {1'b0, div_quo} + {1'b0, start_ff};
         res_slot_in = 9'(div_rem[5:0] * fac_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         req_cnt_ff <= 32'd0;
         hit_cnt_ff <= 32'd0;
      end else begin
         valid_ff   <= valid_in;
         req_cnt_ff <= req_cnt_in;
         hit_cnt_ff <= hit_cnt_in;
      end
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_share_ff  <= res_share_in;
      res_blk_ff    <= res_blk_in;
      res_slot_ff   <= res_slot_in;
   end

   // Result register.
   logic         rsp_valid_ff, rsp_valid_in;
   iclr_rsp_type rsp_ff, rsp_in;
   logic         out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.out_load) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = res_status_ff;
         rsp_in.entry_index   = res_idx_ff;
         rsp_in.inode_block   = res_blk_ff;
         rsp_in.inode_slot    = res_slot_ff;
         rsp_in.share_count   = res_share_ff;
         rsp_in.request_total = req_cnt_ff;
         rsp_in.hit_total     = hit_cnt_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status back to the controller.
   always_comb begin
      st.is_get    = req_ff.req_type == REQ_GET;
      st.put_ok    = put_ok;
      st.scan_done = rv_ff && (ridx_ff == IDX_W'(ENTRIES - 1));
      st.need_div  = (req_ff.req_type == REQ_GET) ? (hit_ff || fill) : put_wb;
      st.div_done  = div_done;
      st.out_free  = out_free;
   end

   // A new word is never loaded over one the receiver has not taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result word overwritten while stalled");

   // A hit always points at a valid entry.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.get_commit && hit_ff) |-> valid_ff[hit_idx_ff])
      else $error("hit on a free entry");

   // Starting the divider clears its done flag.
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !div_done)
      else $error("divider done right after start");

endmodule

FILE: hw/rtl/iclr_ctrl.sv
// ============================================================================
// Inode cache controller
// State machine that sequences request capture, table scan, commit,
// location division and result delivery.
// ============================================================================
module iclr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output iclr_pkg::iclr_cmd_type  cmd,
   input  iclr_pkg::iclr_stat_type st
);
   import iclr_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DISP = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_GDEC = 3'd3;
   localparam logic [2:0] S_PUT  = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_stall = state_ff != S_IDLE;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (st.is_get) begin
               state_in = S_SCAN;
            end else if (st.put_ok) begin
               state_in = S_PUT;
            end else begin
               cmd.set_reject = 1'b1;
               state_in       = S_OUT;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (st.scan_done) begin
               state_in = S_GDEC;
            end
         end
         S_GDEC: begin
            cmd.get_commit = 1'b1;
            cmd.div_start  = st.need_div;
            state_in       = st.need_div ? S_DIV : S_OUT;
         end
         S_PUT: begin
            cmd.put_commit = 1'b1;
            cmd.div_start  = st.need_div;
            state_in       = st.need_div ? S_DIV : S_OUT;
         end
         S_DIV: begin
            if (st.div_done) begin
               cmd.loc_load = 1'b1;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Every accepted word leads to the dispatch step.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_DISP)
      else $error("accepted word not dispatched");

   // The table is only written once a scan has finished or a put was checked.
   assert property (@(posedge clock) disable iff (reset)
      cmd.get_commit |-> $past(state_ff) == S_SCAN)
      else $error("get committed without a scan");

   // A result leaves only from the output state.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> state_ff == S_IDLE)
      else $error("output load outside the output step");

endmodule

FILE: hw/rtl/inode_cache_lfu_refcount_top.sv
// ============================================================================
// Inode cache top level
// Table of cached inodes with use counts and share counts, built from a
// controller and a datapath.
// ============================================================================
// Usage:
// The request channel (req_valid, req_stall, req_data) carries one word per
// get or put. The result channel (rsp_valid, rsp_stall, rsp_data) returns
// exactly one word per request. The csr_ port writes the per-block inode
// count, inode_table_start and inode_size_factor; the user must do so only
// while the block is idle, as the block itself does not enforce it. One
// request is in work at a time. A get reads the 64 table entries one per
// cycle from the entry memory, commits, then a hit or fill runs the
// 1-bit-per-cycle divider before the result is loaded; when nothing is
// evictable the divider is skipped. A put checks its target, commits and
// runs the divider only when it writes back; a null or bad put is rejected
// without a commit.
// A new request is taken as soon as the previous result is in the output
// register, even if the receiver has not taken it yet; while rsp_stall is
// high the result word holds and the next result waits in its final step.
// Reset clears the valid bits and the counters and sets the configuration
// registers to their defaults; no clearing pass is needed.
// ============================================================================
module inode_cache_lfu_refcount_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  iclr_pkg::iclr_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output iclr_pkg::iclr_rsp_type rsp_data,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_wdata
);
   import iclr_pkg::*;

   iclr_cmd_type  cmd;
   iclr_stat_type st;

   // Sequencer.
   iclr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .st        (st)
   );

   // Table, arithmetic and result register.
   iclr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .st        (st),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/inode_cache_lfu_refcount_top_test.sv
`timescale 1ns / 100ps
// ============================================================================
// Inode cache testbench
// Drives get and put words into the inode cache and checks every result word
// against a predictor of the table, its counts and the location arithmetic.
// Directed cases come first, then random traffic under several idle mixes
// and register settings.
// ============================================================================
module inode_cache_lfu_refcount_top_test;
   import iclr_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   iclr_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   iclr_rsp_type rsp_data;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = CSR_IPB;
   logic [31:0]  csr_wdata = '0;

   inode_cache_lfu_refcount_top dut (.*);

   always #5 clock = ~clock;

   // Predicted table state and registers.
   logic        tbl_valid [ENTRIES];
   logic [7:0]  tbl_dev   [ENTRIES];
   logic [31:0] tbl_ino   [ENTRIES];
   logic [15:0] tbl_use   [ENTRIES];
   logic [7:0]  tbl_users [ENTRIES];
   logic        tbl_modf  [ENTRIES];
   logic [31:0] get_count, hit_count;
   logic [6:0]  cfg_ipb;
   logic [31:0] cfg_start;
   logic [3:0]  cfg_fac;

   iclr_rsp_type expected_rsp [$];
   int mismatches = 0;
   int words_checked = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;

   // Block and slot of an inode under the current registers.
   function automatic void locate_inode(input logic [31:0] ino,
                                        output logic [32:0] blk,
                                        output logic [8:0] slot);
      logic [31:0] ipb, fac, idx;
      ipb = (cfg_ipb == 0) ? 1 : (cfg_ipb > 64) ? 64 : cfg_ipb;
      fac = (cfg_fac == 0) ? 1 : (cfg_fac > 8) ? 8 : cfg_fac;
      idx = ino - 32'd1;
      blk = {1'b0, idx / ipb} + {1'b0, cfg_start};
      slot = 9'((idx % ipb) * fac);
   endfunction

   // Apply one request word to the predicted table and build its result.
   function automatic iclr_rsp_type cache_step(input iclr_req_type rq);
      iclr_rsp_type r;
      int pick;
      logic done;
      r = '0;
      done = 1'b0;
      if (rq.req_type == REQ_GET) begin
         get_count++;
         for (int i = 0; i < ENTRIES && !done; i++) begin
            if (tbl_valid[i] && tbl_dev[i] == rq.dev && tbl_ino[i] == rq.ino) begin
               if (tbl_use[i] != USE_MAX) tbl_use[i]++;
               if (tbl_users[i] != USERS_MAX) tbl_users[i]++;
               hit_count++;
               r.status = ST_HIT;
               r.entry_index = 6'(i);
               r.share_count = tbl_users[i];
               locate_inode(rq.ino, r.inode_block, r.inode_slot);
               done = 1'b1;
            end
         end
         if (!done) begin
            pick = -1;
            for (int i = 0; i < ENTRIES; i++)
               if (pick < 0 && !tbl_valid[i]) pick = i;
            if (pick >= 0) r.status = ST_FREE;
            else begin
               for (int i = 0; i < ENTRIES; i++)
                  if (tbl_users[i] == 0 && (pick < 0 || tbl_use[i] < tbl_use[pick]))
                     pick = i;
               r.status = (pick >= 0) ? ST_EVICT : ST_NONE;
            end
            if (pick >= 0) begin
               tbl_valid[pick] = 1'b1;
               tbl_dev[pick] = rq.dev;
               tbl_ino[pick] = rq.ino;
               tbl_use[pick] = 16'd1;
               tbl_users[pick] = 8'd1;
               tbl_modf[pick] = 1'b0;
               r.entry_index = 6'(pick);
               r.share_count = 8'd1;
               locate_inode(rq.ino, r.inode_block, r.inode_slot);
            end
         end
      end else if (!rq.has_entry) begin
         r.status = ST_NULL_PUT;
      end else if (!tbl_valid[rq.target_entry]) begin
         r.status = ST_BAD_PUT;
         r.entry_index = rq.target_entry;
      end else begin
         r.entry_index = rq.target_entry;
         if (rq.dirty) tbl_modf[rq.target_entry] = 1'b1;
         if (tbl_users[rq.target_entry] != 0) tbl_users[rq.target_entry]--;
         r.share_count = tbl_users[rq.target_entry];
         if (tbl_users[rq.target_entry] == 0 && tbl_modf[rq.target_entry]) begin
            r.status = ST_PUT_WB;
            locate_inode(tbl_ino[rq.target_entry], r.inode_block, r.inode_slot);
            tbl_modf[rq.target_entry] = 1'b0;
         end else begin
            r.status = ST_PUT_NOWR;
         end
      end
      r.request_total = get_count;
      r.hit_total = hit_count;
      return r;
   endfunction

   // Send one word; the valid stays high across back-to-back words and is
   // dropped by an idle cycle or by the drain wait.
   task automatic send_word(input iclr_req_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsp.push_back(cache_step(rq));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   // Registers are written only once the block has drained.
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_IPB:   cfg_ipb = val[6:0];
         CSR_START: cfg_start = val;
         CSR_FAC:   cfg_fac = val[3:0];
         default: ;
      endcase
   endtask

   function automatic iclr_req_type make_get(input logic [7:0] d, input logic [31:0] n);
      iclr_req_type rq;
      rq = '0;
      rq.req_type = REQ_GET;
      rq.dev = d;
      rq.ino = n;
      rq.target_entry = 6'($urandom);
      rq.has_entry = 1'($urandom);
      rq.dirty = 1'($urandom);
      return rq;
   endfunction

   function automatic iclr_req_type make_put(input logic [5:0] e, input logic h,
                                             input logic dt);
      iclr_req_type rq;
      rq = '0;
      rq.req_type = REQ_PUT;
      rq.dev = 8'($urandom);
      rq.ino = $urandom;
      rq.target_entry = e;
      rq.has_entry = h;
      rq.dirty = dt;
      return rq;
   endfunction

   // Random word: gets on a small key space so hits and fills mix, puts on
   // mostly live entries.
   function automatic iclr_req_type random_word();
      int k;
      k = $urandom_range(99);
      if (k < 50)
         return make_get(8'($urandom_range(3)), $urandom_range(90));
      else if (k < 55)
         return make_get(8'($urandom), $urandom);
      else if (k < 90)
         return make_put(6'($urandom), 1'b1, 1'($urandom));
      else
         return make_put(6'($urandom), 1'($urandom), 1'($urandom));
   endfunction

   // Result checker: compare each accepted word with the oldest prediction.
   always @(posedge clock) begin
      iclr_rsp_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result word %h", rsp_data);
         end else begin
            exp_w = expected_rsp.pop_front();
            words_checked++;
            if (exp_w.status != rsp_data.status ||
                exp_w.entry_index != rsp_data.entry_index ||
                exp_w.inode_block != rsp_data.inode_block ||
                exp_w.inode_slot != rsp_data.inode_slot ||
                exp_w.share_count != rsp_data.share_count ||
                exp_w.request_total != rsp_data.request_total ||
                exp_w.hit_total != rsp_data.hit_total) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %p, got %p", exp_w, rsp_data);
            end
         end
      end
   end

   // Receiver stall: a long hold when requested, else random idling.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic test_directed();
      send_word(make_get(8'd0, 32'd1));
      send_word(make_get(8'd255, 32'hFFFF_FFFF));
      send_word(make_get(8'd0, 32'd0));
      send_word(make_get(8'd0, 32'd1));
      send_word(make_put(6'd0, 1'b1, 1'b0));
      send_word(make_put(6'd0, 1'b1, 1'b1));
      send_word(make_put(6'd0, 1'b1, 1'b1));
      send_word(make_put(6'd0, 1'b1, 1'b0));
      send_word(make_put(6'd63, 1'b1, 1'b0));
      send_word(make_put(6'd1, 1'b0, 1'b1));
      send_word(make_put(6'd2, 1'b1, 1'b1));
   endtask

   // Fill the table, then exercise eviction and the no-victim case.
   task automatic test_eviction();
      for (int i = 0; i < ENTRIES; i++) send_word(make_get(8'd9, 32'(1000 + i)));
      send_word(make_get(8'd9, 32'd5000));
      for (int i = 0; i < ENTRIES; i++)
         if (tbl_users[i] == 0) send_word(make_get(tbl_dev[i], tbl_ino[i]));
      send_word(make_get(8'd9, 32'd5001));
      for (int i = 0; i < 8; i++) send_word(make_put(6'(i), 1'b1, 1'b1));
      send_word(make_get(8'd9, 32'd5002));
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) send_word(random_word());
   endtask

   // Hold the receiver while the sender keeps offering words.
   task automatic test_backpressure();
      wait_drained();
      @(negedge clock);
      hold_cycles = 600;
      test_random(12);
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         tbl_valid[i] = 1'b0; tbl_dev[i] = '0; tbl_ino[i] = '0;
         tbl_use[i] = '0; tbl_users[i] = '0; tbl_modf[i] = 1'b0;
      end
      get_count = '0; hit_count = '0;
      cfg_ipb = 7'd8; cfg_start = '0; cfg_fac = 4'd1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_eviction();
      send_idle_pct = 27; recv_idle_pct = 75;
      write_reg(CSR_IPB, 32'd1);
      write_reg(CSR_START, 32'hFFFF_FFFF);
      write_reg(CSR_FAC, 32'd8);
      test_random(450);
      test_backpressure();
      send_idle_pct = 75; recv_idle_pct = 27;
      write_reg(CSR_IPB, 32'd64);
      write_reg(CSR_START, 32'h1234_5678);
      write_reg(CSR_FAC, 32'd0);
      test_random(450);
      send_idle_pct = 0; recv_idle_pct = 0;
      write_reg(CSR_IPB, 32'd127);
      write_reg(CSR_START, 32'd0);
      write_reg(CSR_FAC, 32'd15);
      test_random(300);
      write_reg(CSR_IPB, 32'd0);
      write_reg(CSR_FAC, 32'd3);
      test_random(300);
      wait_drained();
      $display("Checked %0d result words over gets, puts, evictions and five register sets.",
               words_checked);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_rsp.size());
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #20ms;
      $display("Timeout");
      $display("Mismatches found");
      $finish;
   end

endmodule
